// File: hdl/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// shared types, codes and helpers for the side-band line deframer
// ----------------------------------------------------------------------------
package psd_pkg;

  // event codes carried on the result channel
  typedef enum logic [2:0] {
    EV_PACK    = 3'd0,
    EV_PROG    = 3'd1,
    EV_NAK     = 3'd2,
    EV_ACK     = 3'd3,
    EV_UNKNOWN = 3'd4,
    EV_FLUSH   = 3'd5,
    EV_ERROR   = 3'd6
  } event_e;

  // framing phase
  typedef enum logic [2:0] {
    PH_LEN = 3'b001,
    PH_PAY = 3'b010,
    PH_ERR = 3'b100
  } phase_e;

  // kind of the current line
  typedef enum logic [5:0] {
    KD_NONE = 6'b000001,
    KD_PACK = 6'b000010,
    KD_PROG = 6'b000100,
    KD_NAK  = 6'b001000,
    KD_ACK  = 6'b010000,
    KD_SKIP = 6'b100000
  } kind_e;

  localparam logic [7:0] ChanPack = 8'h01;
  localparam logic [7:0] ChanProg = 8'h02;
  localparam logic [7:0] ChrN     = 8'h4e;
  localparam logic [7:0] ChrA     = 8'h41;
  localparam logic [7:0] ChrK     = 8'h4b;
  localparam logic [7:0] ChrC     = 8'h43;
  localparam logic [3:0] HexTen   = 4'ha;

  localparam logic [15:0] LenHeader = 16'd4;

  // one result item
  typedef struct packed {
    event_e     ev;
    logic [7:0] data;
    logic       last;
  } res_t;

  function automatic logic hex_ok(input logic [7:0] c);
    logic r;
    r = (c inside {["0":"9"], ["a":"f"], ["A":"F"]});
    return r;
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] r;
    if (c inside {["0":"9"]}) begin
      r = 4'(c - 8'h30);
    end else if (c inside {["a":"f"]}) begin
      r = 4'(c - 8'h61) + HexTen;
    end else if (c inside {["A":"F"]}) begin
      r = 4'(c - 8'h41) + HexTen;
    end else begin
      r = 4'd0;
    end
    return r;
  endfunction

endpackage

// File: hdl/psd_in_reg.sv
// ----------------------------------------------------------------------------
// psd_in_reg
// input register: holds one received byte until the deframer takes it
// ----------------------------------------------------------------------------
module psd_in_reg import psd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] stream_byte_i,
  input  logic       take_i,
  output logic       vld_o,
  output logic [7:0] byte_o
);

  logic       vld_q, vld_d;
  logic [7:0] byte_q, byte_d;

  // full and not drained this cycle
  assign in_stall_o = vld_q & ~take_i;

  always_comb begin
    vld_d  = vld_q;
    byte_d = byte_q;
    if (!in_stall_o) begin
      vld_d = in_valid_i;
      if (in_valid_i) begin
        byte_d = stream_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign vld_o  = vld_q;
  assign byte_o = byte_q;

endmodule

// File: hdl/psd_step.sv
// ----------------------------------------------------------------------------
// psd_step
// framing state and per-byte decision logic
// ----------------------------------------------------------------------------
module psd_step import psd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] byte_i,
  output logic       res_vld_o,
  output res_t       res_o
);

  phase_e      phase_q, phase_d;
  logic [1:0]  digit_cnt_q, digit_cnt_d;
  logic [15:0] left_q, left_d;
  kind_e       kind_q, kind_d;
  logic        match_two_q, match_two_d;

  logic        res_vld;
  res_t        res;
  logic [15:0] acc;
  logic [15:0] left_dec;
  logic        last;
  logic [7:0]  want;

  assign acc      = {left_q[11:0], hex_val(byte_i)};
  assign left_dec = left_q - 16'd1;
  assign last     = (left_dec == '0);

  always_comb begin
    if (kind_q == KD_NAK) begin
      want = match_two_q ? ChrK : ChrA;
    end else begin
      want = match_two_q ? ChrK : ChrC;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    digit_cnt_d = digit_cnt_q;
    left_d      = left_q;
    kind_d      = kind_q;
    match_two_d = match_two_q;
    res_vld     = 1'b0;
    res         = '{ev: EV_PACK, data: 8'd0, last: 1'b0};

    case (phase_q)
      PH_LEN: begin
        if (!hex_ok(byte_i)) begin
          phase_d     = PH_ERR;
          digit_cnt_d = '0;
          left_d      = '0;
          kind_d      = KD_NONE;
          match_two_d = 1'b0;
          res_vld     = 1'b1;
          res.ev      = EV_ERROR;
        end else if (digit_cnt_q != 2'd3) begin
          left_d      = acc;
          digit_cnt_d = digit_cnt_q + 2'd1;
        end else begin
          digit_cnt_d = '0;
          kind_d      = KD_NONE;
          match_two_d = 1'b0;
          if (acc == '0) begin
            left_d  = '0;
            res_vld = 1'b1;
            res.ev  = EV_FLUSH;
          end else if (acc < LenHeader) begin
            phase_d = PH_ERR;
            left_d  = '0;
            res_vld = 1'b1;
            res.ev  = EV_ERROR;
          end else if (acc == LenHeader) begin
            left_d = '0;
          end else begin
            left_d  = acc - LenHeader;
            phase_d = PH_PAY;
          end
        end
      end

      PH_PAY: begin
        left_d = left_dec;
        case (kind_q)
          KD_NONE: begin
            if (byte_i == ChanPack) begin
              kind_d = KD_PACK;
            end else if (byte_i == ChanProg) begin
              kind_d = KD_PROG;
            end else if (byte_i == ChrN || byte_i == ChrA) begin
              kind_d      = (byte_i == ChrN) ? KD_NAK : KD_ACK;
              match_two_d = 1'b0;
              if (last) begin
                res_vld = 1'b1;
                res.ev  = EV_UNKNOWN;
              end
            end else begin
              kind_d  = KD_SKIP;
              res_vld = 1'b1;
              res.ev  = EV_UNKNOWN;
            end
          end
          KD_NAK, KD_ACK: begin
            if (byte_i != want) begin
              kind_d  = KD_SKIP;
              res_vld = 1'b1;
              res.ev  = EV_UNKNOWN;
            end else if (match_two_q) begin
              kind_d  = KD_SKIP;
              res_vld = 1'b1;
              res.ev  = (kind_q == KD_NAK) ? EV_NAK : EV_ACK;
            end else begin
              match_two_d = 1'b1;
              if (last) begin
                res_vld = 1'b1;
                res.ev  = EV_UNKNOWN;
              end
            end
          end
          KD_PACK: begin
            res_vld = 1'b1;
            res     = '{ev: EV_PACK, data: byte_i, last: last};
          end
          KD_PROG: begin
            res_vld = 1'b1;
            res     = '{ev: EV_PROG, data: byte_i, last: last};
          end
          default: begin
          end
        endcase
        // line done: back to the length field
        if (last) begin
          phase_d     = PH_LEN;
          digit_cnt_d = '0;
          left_d      = '0;
          kind_d      = KD_NONE;
          match_two_d = 1'b0;
        end
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LEN;
      digit_cnt_q <= '0;
      left_q      <= '0;
      kind_q      <= KD_NONE;
      match_two_q <= 1'b0;
    end else if (fire_i) begin
      phase_q     <= phase_d;
      digit_cnt_q <= digit_cnt_d;
      left_q      <= left_d;
      kind_q      <= kind_d;
      match_two_q <= match_two_d;
    end
  end

  assign res_vld_o = fire_i & res_vld;
  assign res_o     = res;

`ifndef ASSERT_OFF
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_ERR |=> phase_q == PH_ERR)
    else $error("error phase left before reset");

  a_err_from_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_o && res_o.ev == EV_ERROR |-> phase_q == PH_LEN)
    else $error("error event outside the length field");

  a_data_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_o && (res_o.ev == EV_PACK || res_o.ev == EV_PROG)
      |-> phase_q == PH_PAY && (kind_q == KD_PACK || kind_q == KD_PROG))
    else $error("payload byte emitted outside a data line");

  a_digits_in_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_cnt_q != 2'd0 |-> phase_q == PH_LEN)
    else $error("digit count set outside the length field");
`endif

endmodule

// File: hdl/psd_out_reg.sv
// ----------------------------------------------------------------------------
// psd_out_reg
// result register facing the receiver
// ----------------------------------------------------------------------------
module psd_out_reg import psd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  logic       res_vld_i,
  input  res_t       res_i,
  output logic       ready_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] event_res_o,
  output logic [7:0] data_byte_o,
  output logic       last_in_line_o
);

  logic vld_q, vld_d;
  res_t res_q, res_d;

  // free, or the held result leaves this cycle
  assign ready_o = ~vld_q | ~out_stall_i;

  always_comb begin
    vld_d = vld_q;
    res_d = res_q;
    if (ready_o) begin
      vld_d = load_i & res_vld_i;
      if (load_i && res_vld_i) begin
        res_d = res_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o    = vld_q;
  assign event_res_o    = res_q.ev;
  assign data_byte_o    = res_q.data;
  assign last_in_line_o = res_q.last;

endmodule

// File: hdl/pkt_line_sideband_demux.sv
// ----------------------------------------------------------------------------
// pkt_line_sideband_demux
// byte-serial deframer for a length-prefixed line stream with side-band
// channels
// ----------------------------------------------------------------------------
// usage:
//   input channel: one stream byte per transfer (in_valid_i / in_stall_o)
//   output channel: at most one event per byte (out_valid_o / out_stall_i),
//     carrying the event code, the payload byte and the end-of-line flag
//   bytes that cause no event (length digits, channel byte, skipped line
//   text, everything after an error) are consumed silently
// path: an accepted byte waits in the input register until it is decided;
//   its event goes into the result register: one register in, one out
// throughput: one byte per clock unless the receiver stalls; the decision
//   is a single pass of short logic (hex decode, 16-bit decrement and
//   compare) between the input register and the result register
// reset: both registers empty, framing back to reading length digits,
//   sticky error cleared
// receiver stall: the held event stays put, a byte is still taken into an
//   empty input register, then in_stall_o rises until the event leaves
// ----------------------------------------------------------------------------
module pkt_line_sideband_demux import psd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] stream_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] event_res_o,
  output logic [7:0] data_byte_o,
  output logic       last_in_line_o
);

  logic       byte_vld;
  logic [7:0] byte_val;
  logic       out_ready;
  logic       fire;
  logic       res_vld;
  res_t       res;

  // a byte is processed when it is held and the result register can load
  assign fire = byte_vld & out_ready;

  // input side: one-byte holding register
  psd_in_reg u_in_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .stream_byte_i (stream_byte_i),
    .take_i        (fire),
    .vld_o         (byte_vld),
    .byte_o        (byte_val)
  );

  // framing state and per-byte decision
  psd_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .byte_i    (byte_val),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  // output side: result register toward the receiver
  psd_out_reg u_out_reg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (fire),
    .res_vld_i      (res_vld),
    .res_i          (res),
    .ready_o        (out_ready),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_res_o    (event_res_o),
    .data_byte_o    (data_byte_o),
    .last_in_line_o (last_in_line_o)
  );

endmodule

// File: bench/pkt_line_sideband_demux_test.sv
// ----------------------------------------------------------------------------
// pkt_line_sideband_demux_test
// self-checking bench for the side-band line deframer: a byte stream of
// framed lines (pack, progress, NAK/ACK, unknown, broken, empty, flush) is
// pushed through the input channel under several idle and stall mixes, every
// accepted byte runs through a local model of the framing, and each event
// transfer is checked field by field against the oldest predicted event. The
// run closes with one sticky framing error and a few bytes that must be
// swallowed silently.
// ----------------------------------------------------------------------------
module pkt_line_sideband_demux_test;
  timeunit 1ns;
  timeprecision 1ps;

  import psd_pkg::*;

  // generous bound: every byte waiting out long sender gaps and stalls
  localparam int unsigned CycleLimit = 400000;
  // bytes of random lines per idle mix
  localparam int unsigned PhaseBytes = 325;
  // mismatch lines printed before going quiet (all are still counted)
  localparam int unsigned PrintCap   = 200;

  // dut ports
  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic       in_stall_o;
  logic [7:0] stream_byte_i  = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i    = 1'b0;
  logic [2:0] event_res_o;
  logic [7:0] data_byte_o;
  logic       last_in_line_o;

  // stimulus and scoreboard storage
  logic [7:0]  stream_q[$];       // bytes waiting to be offered
  res_t        expected_events[$]; // predicted events, oldest first
  int unsigned bytes_queued   = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches     = 0;
  int unsigned cycle_count    = 0;
  logic        byte_taken     = 1'b0;

  // local copy of the framing state
  phase_e      frm_phase       = PH_LEN;
  logic [1:0]  digits_seen     = 2'd0;
  logic [15:0] remaining       = 16'd0;
  kind_e       kind            = KD_NONE;
  logic [1:0]  letters_matched = 2'd0;

  pkt_line_sideband_demux dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .stream_byte_i  (stream_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_res_o    (event_res_o),
    .data_byte_o    (data_byte_o),
    .last_in_line_o (last_in_line_o)
  );

  // 10 ns clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ------------------------------------------------------------------------
  // framing model
  // ------------------------------------------------------------------------

  // {ok, value} for one length digit; only 0-9, a-f and A-F are digits
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) begin
      return {1'b1, c[3:0]};
    end
    if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      return {1'b1, HexTen + 4'(c[2:0]) - 4'd1};
    end
    return 5'd0;
  endfunction

  // back to waiting for the four length digits
  task automatic restart_framing();
    frm_phase       = PH_LEN;
    digits_seen     = 2'd0;
    remaining       = 16'd0;
    kind            = KD_NONE;
    letters_matched = 2'd0;
  endtask

  // advance the model by one accepted byte, queue the event it causes
  task automatic deframe_byte(input logic [7:0] b);
    logic [4:0]  digit;
    logic [15:0] acc;
    logic        at_end;
    logic [7:0]  want;
    logic        fire;
    res_t        ev;
    fire    = 1'b0;
    ev.ev   = EV_PACK;
    ev.data = 8'h00;
    ev.last = 1'b0;
    case (frm_phase)
      PH_LEN: begin
        digit = hex_digit(b);
        if (!digit[4]) begin
          // bad digit: sticky error
          restart_framing();
          frm_phase = PH_ERR;
          fire      = 1'b1;
          ev.ev     = EV_ERROR;
        end else begin
          acc = {remaining[11:0], digit[3:0]};
          if (digits_seen < 2'd3) begin
            remaining   = acc;
            digits_seen = digits_seen + 2'd1;
          end else if (acc == 16'd0) begin
            // flush event, then back to the length digits
            restart_framing();
            fire  = 1'b1;
            ev.ev = EV_FLUSH;
          end else if (acc < LenHeader) begin
            // length shorter than its own header
            restart_framing();
            frm_phase = PH_ERR;
            fire      = 1'b1;
            ev.ev     = EV_ERROR;
          end else if (acc == LenHeader) begin
            // empty line, straight back to the next length
            restart_framing();
          end else begin
            remaining       = acc - LenHeader;
            digits_seen     = 2'd0;
            frm_phase       = PH_PAY;
            kind            = KD_NONE;
            letters_matched = 2'd0;
          end
        end
      end
      PH_PAY: begin
        remaining = remaining - 16'd1;
        at_end    = (remaining == 16'd0);
        case (kind)
          KD_NONE: begin
            // first payload byte picks the channel
            if (b == ChanPack) begin
              kind = KD_PACK;
            end else if (b == ChanProg) begin
              kind = KD_PROG;
            end else if (b == ChrN || b == ChrA) begin
              kind            = (b == ChrN) ? KD_NAK : KD_ACK;
              letters_matched = 2'd1;
              if (at_end) begin
                fire  = 1'b1;
                ev.ev = EV_UNKNOWN;
              end
            end else begin
              kind  = KD_SKIP;
              fire  = 1'b1;
              ev.ev = EV_UNKNOWN;
            end
          end
          KD_NAK, KD_ACK: begin
            if (kind == KD_NAK) begin
              want = (letters_matched == 2'd1) ? ChrA : ChrK;
            end else begin
              want = (letters_matched == 2'd1) ? ChrC : ChrK;
            end
            if (b != want) begin
              kind  = KD_SKIP;
              fire  = 1'b1;
              ev.ev = EV_UNKNOWN;
            end else if (letters_matched >= 2'd2) begin
              fire  = 1'b1;
              ev.ev = (kind == KD_NAK) ? EV_NAK : EV_ACK;
              kind  = KD_SKIP;
            end else begin
              letters_matched = 2'd2;
              if (at_end) begin
                fire  = 1'b1;
                ev.ev = EV_UNKNOWN;
              end
            end
          end
          KD_PACK, KD_PROG: begin
            fire    = 1'b1;
            ev.ev   = (kind == KD_PACK) ? EV_PACK : EV_PROG;
            ev.data = b;
            ev.last = at_end;
          end
          default: begin
            // rest of a skipped line
          end
        endcase
        if (at_end) begin
          restart_framing();
        end
      end
      default: begin
        // sticky error: bytes vanish until reset
      end
    endcase
    if (fire) begin
      expected_events.push_back(ev);
    end
  endtask

  // ------------------------------------------------------------------------
  // checking
  // ------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    if (mismatches < PrintCap) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  // both channels are watched at the rising edge; the output transfer is
  // checked before the input transfer adds its prediction, so a byte taken
  // at this edge can never be matched against an event of the same edge
  always @(posedge clk_i) begin
    res_t want;
    byte_taken = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("event %0d with nothing pending", event_res_o));
        end else begin
          want = expected_events.pop_front();
          if (event_res_o !== want.ev) begin
            report_mismatch($sformatf("event_res got %0d expected %0d",
                                      event_res_o, want.ev));
          end
          if (data_byte_o !== want.data) begin
            report_mismatch($sformatf("data_byte got %02h expected %02h",
                                      data_byte_o, want.data));
          end
          if (last_in_line_o !== want.last) begin
            report_mismatch($sformatf("last_in_line got %0b expected %0b",
                                      last_in_line_o, want.last));
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        byte_taken = 1'b1;
        deframe_byte(stream_byte_i);
        void'(stream_q.pop_front());
      end
    end
  end

  // ------------------------------------------------------------------------
  // driver: inputs move only at the falling edge
  // ------------------------------------------------------------------------

  // a held byte stays put until its transfer; a new one is offered only
  // after the previous transfer, so valid never follows stall
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || byte_taken) begin
        if (stream_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i    <= 1'b1;
          stream_byte_i <= stream_q[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // run guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // stream construction
  // ------------------------------------------------------------------------

  task automatic push_byte(input logic [7:0] b);
    stream_q.push_back(b);
    bytes_queued++;
  endtask

  // one hex character, letters in random case
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < HexTen) begin
      return 8'h30 + 8'(n);
    end
    return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(n - HexTen);
  endfunction

  // four length digits for a line of the given total length
  task automatic push_length(input logic [15:0] total);
    push_byte(hex_char(total[15:12]));
    push_byte(hex_char(total[11:8]));
    push_byte(hex_char(total[7:4]));
    push_byte(hex_char(total[3:0]));
  endtask

  function automatic logic [7:0] random_except(input logic [7:0] avoid);
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (b == avoid) begin
      b = 8'($urandom_range(255));
    end
    return b;
  endfunction

  task automatic push_random_bytes(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      push_byte(8'($urandom_range(255)));
    end
  endtask

  // one well-formed or deliberately broken line, never a framing error
  task automatic push_random_line();
    int unsigned pick;
    int unsigned body;
    logic [7:0]  first;
    logic [7:0]  second;
    pick = $urandom_range(99);
    // mostly short lines, now and then a long one
    body = ($urandom_range(19) == 0) ? $urandom_range(300) : $urandom_range(24);
    if (pick < 4) begin
      push_length(16'd0);
    end else if (pick < 7) begin
      push_length(LenHeader);
    end else if (pick < 52) begin
      // pack or progress data
      push_length(16'(body) + LenHeader + 16'd1);
      push_byte((pick < 32) ? ChanPack : ChanProg);
      push_random_bytes(body);
    end else if (pick < 72) begin
      // complete NAK or ACK, with trailing text
      push_length(16'(body) + LenHeader + 16'd3);
      if (pick < 62) begin
        push_byte(ChrN);
        push_byte(ChrA);
      end else begin
        push_byte(ChrA);
        push_byte(ChrC);
      end
      push_byte(ChrK);
      push_random_bytes(body);
    end else if (pick < 87) begin
      // broken NAK/ACK: cut short or a wrong letter
      first  = $urandom_range(1) ? ChrN : ChrA;
      second = (first == ChrN) ? ChrA : ChrC;
      case ($urandom_range(3))
        0: begin
          push_length(LenHeader + 16'd1);
          push_byte(first);
        end
        1: begin
          push_length(LenHeader + 16'd2);
          push_byte(first);
          push_byte(second);
        end
        2: begin
          push_length(16'(body) + LenHeader + 16'd2);
          push_byte(first);
          push_byte(random_except(second));
          push_random_bytes(body);
        end
        default: begin
          push_length(16'(body) + LenHeader + 16'd3);
          push_byte(first);
          push_byte(second);
          push_byte(random_except(ChrK));
          push_random_bytes(body);
        end
      endcase
    end else begin
      // unknown line
      first = 8'($urandom_range(255));
      while (first == ChanPack || first == ChanProg || first == ChrN || first == ChrA) begin
        first = 8'($urandom_range(255));
      end
      push_length(16'(body) + LenHeader + 16'd1);
      push_byte(first);
      push_random_bytes(body);
    end
  endtask

  // ------------------------------------------------------------------------
  // test sequence
  // ------------------------------------------------------------------------

  initial begin
    int unsigned pct_send[4];
    int unsigned pct_recv[4];
    int unsigned lead;
    logic [7:0]  bad;
    // idle mixes: none, sender gaps, receiver stalls, both
    pct_send = '{0, 60, 0, 26};
    pct_recv = '{0, 0, 60, 26};

    // single reset, released away from the rising edge
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed lines: flush, empty line, channel byte alone, progress with
    // byte extremes and end flag, NAK cut off after two letters
    push_length(16'd0);
    push_length(LenHeader);
    push_length(LenHeader + 16'd1);
    push_byte(ChanPack);
    push_length(LenHeader + 16'd3);
    push_byte(ChanProg);
    push_byte(8'h00);
    push_byte(8'hff);
    push_length(LenHeader + 16'd2);
    push_byte(ChrN);
    push_byte(ChrA);

    // random lines under each idle mix
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = pct_send[p];
      recv_stall_pct = pct_recv[p];
      bytes_queued   = 0;
      while (bytes_queued < PhaseBytes) begin
        push_random_line();
      end
      while (stream_q.size() != 0) begin
        @(posedge clk_i);
      end
    end

    // sticky error last, since only reset clears it: either a non-hex
    // byte among the length digits or a length below the header size
    if ($urandom_range(1)) begin
      lead = $urandom_range(3);
      for (int unsigned i = 0; i < lead; i++) begin
        push_byte(hex_char(4'($urandom_range(15))));
      end
      bad = 8'($urandom_range(255));
      while (hex_digit(bad) != 5'd0) begin
        bad = 8'($urandom_range(255));
      end
      push_byte(bad);
    end else begin
      push_length(16'($urandom_range(1, 3)));
    end
    // all of these must vanish
    push_random_bytes(8);

    // drain, then give the result register time to show a stray event
    while (stream_q.size() != 0 || expected_events.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (20) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
